>>> sv/lav_pkg.sv
// shared widths, constants and vector types of the look-at view matrix unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lav_pkg;

  // field widths on the stream ports
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SHIFT_W = 24;
  localparam int unsigned IN_W    = 9 * COORD_W;
  localparam int unsigned OUT_W   = 9 * COORD_W + 3 * SHIFT_W;

  // internal vector widths
  localparam int unsigned DIFF_W  = COORD_W + 1;  // target - eye, Q8.8
  localparam int unsigned RAW_W   = 31;           // cross products before scaling
  localparam int unsigned FRAC_W  = 14;           // fraction bits of a unit component

  // unit-length scaler
  localparam int unsigned SQ_W       = 62;        // sum of squares, normalized window
  localparam int unsigned MAG_W      = 31;        // component magnitude after scaling up
  localparam int unsigned ROOT_W     = 31;        // bits of the square root
  localparam int unsigned QUO_W      = 15;        // bits of a unit component magnitude
  localparam int unsigned NORM_STEPS = 5;         // shift stages 32, 16, 8, 4, 2

  localparam int unsigned UNIT_ONE = 16384;       // 1.0 in Q1.14

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [2:0] vec_t;

endpackage

`default_nettype wire

>>> sv/lav_unit.sv
// pipelined scaling of a signed 3-vector to unit length in Q1.14
// sum of squares, even normalizing shift, digit-by-digit square root, three dividers
// depends on lav_pkg
`timescale 1ns / 1ps
`default_nettype none

module lav_unit #(
  parameter int unsigned CW = 17,
  parameter int unsigned SW = 96
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2:0][CW-1:0]  c_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output lav_pkg::vec_t       u_o,
  output logic [SW-1:0]       side_o
);
  import lav_pkg::*;

  localparam int unsigned BandW = SW + 3;
  localparam int unsigned RemW  = ROOT_W + 1;
  localparam int unsigned NumW  = MAG_W + FRAC_W + 1;
  localparam int unsigned Depth = 3 + NORM_STEPS + ROOT_W + 1 + QUO_W + 1;

  logic [Depth-1:0] vld_q;
  logic [BandW-1:0] band_q [Depth];

  logic [2:0][CW-1:0]     mag_d, mag_q, mag2_q;
  logic [2:0][2*CW-1:0]   sq_q;
  logic [SQ_W-1:0]        s_q;
  logic [2:0][MAG_W-1:0]  am_q;

  logic [SQ_W-1:0]        nx_in [NORM_STEPS];
  logic [SQ_W-1:0]        nx_d  [NORM_STEPS];
  logic [SQ_W-1:0]        nx_q  [NORM_STEPS];
  logic [2:0][MAG_W-1:0]  nm_in [NORM_STEPS];
  logic [2:0][MAG_W-1:0]  nm_d  [NORM_STEPS];
  logic [2:0][MAG_W-1:0]  nm_q  [NORM_STEPS];

  logic [SQ_W-1:0]        sx_in [ROOT_W];
  logic [SQ_W-1:0]        sx_d  [ROOT_W];
  logic [SQ_W-1:0]        sx_q  [ROOT_W];
  logic [RemW-1:0]        sr_in [ROOT_W];
  logic [RemW-1:0]        sr_d  [ROOT_W];
  logic [RemW-1:0]        sr_q  [ROOT_W];
  logic [ROOT_W-1:0]      sroot_in [ROOT_W];
  logic [ROOT_W-1:0]      sroot_d  [ROOT_W];
  logic [ROOT_W-1:0]      sroot_q  [ROOT_W];
  logic [2:0][MAG_W-1:0]  sm_in [ROOT_W];
  logic [2:0][MAG_W-1:0]  sm_d  [ROOT_W];
  logic [2:0][MAG_W-1:0]  sm_q  [ROOT_W];

  logic [ROOT_W-1:0]      fq_q;
  logic [2:0][ROOT_W-1:0] frem_d, frem_q;
  logic [2:0][QUO_W-1:0]  flo_d, flo_q;

  logic [ROOT_W-1:0]      dq_in   [QUO_W];
  logic [ROOT_W-1:0]      dq_q    [QUO_W];
  logic [2:0][ROOT_W-1:0] drem_in [QUO_W];
  logic [2:0][ROOT_W-1:0] drem_d  [QUO_W];
  logic [2:0][ROOT_W-1:0] drem_q  [QUO_W];
  logic [2:0][QUO_W-1:0]  dlo_in  [QUO_W];
  logic [2:0][QUO_W-1:0]  dlo_d   [QUO_W];
  logic [2:0][QUO_W-1:0]  dlo_q   [QUO_W];
  logic [2:0][QUO_W-1:0]  dquo_in [QUO_W];
  logic [2:0][QUO_W-1:0]  dquo_d  [QUO_W];
  logic [2:0][QUO_W-1:0]  dquo_q  [QUO_W];

  vec_t u_d, u_q;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end

  // component signs and caller sideband ride along
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      band_q[0] <= {c_i[2][CW-1], c_i[1][CW-1], c_i[0][CW-1], side_i};
      for (int k = 1; k < Depth; k++) begin
        band_q[k] <= band_q[k-1];
      end
    end
  end

  // magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = c_i[i][CW-1] ? (~c_i[i] + CW'(1)) : c_i[i];
    end
  end

  // even normalizing shift, magnitudes move by half of it
  always_comb begin
    nx_in[0] = s_q;
    nm_in[0] = am_q;
    for (int g = 1; g < NORM_STEPS; g++) begin
      nx_in[g] = nx_q[g-1];
      nm_in[g] = nm_q[g-1];
    end
    for (int g = 0; g < NORM_STEPS; g++) begin
      if ((nx_in[g] >> (SQ_W - (2 << (NORM_STEPS - 1 - g)))) == '0) begin
        nx_d[g] = nx_in[g] << (2 << (NORM_STEPS - 1 - g));
        for (int i = 0; i < 3; i++) begin
          nm_d[g][i] = nm_in[g][i] << (1 << (NORM_STEPS - 1 - g));
        end
      end else begin
        nx_d[g] = nx_in[g];
        nm_d[g] = nm_in[g];
      end
    end
  end

  // square root, one result bit per stage
  always_comb begin
    logic [RemW+1:0] cur;
    logic [RemW+1:0] trial;
    sx_in[0]    = nx_q[NORM_STEPS-1];
    sr_in[0]    = '0;
    sroot_in[0] = '0;
    sm_in[0]    = nm_q[NORM_STEPS-1];
    for (int g = 1; g < ROOT_W; g++) begin
      sx_in[g]    = sx_q[g-1];
      sr_in[g]    = sr_q[g-1];
      sroot_in[g] = sroot_q[g-1];
      sm_in[g]    = sm_q[g-1];
    end
    for (int g = 0; g < ROOT_W; g++) begin
      cur     = {sr_in[g], sx_in[g][SQ_W-1 -: 2]};
      trial   = {1'b0, sroot_in[g], 2'b01};
      sx_d[g] = sx_in[g] << 2;
      sm_d[g] = sm_in[g];
      if (cur >= trial) begin
        sr_d[g]    = RemW'(cur - trial);
        sroot_d[g] = {sroot_in[g][ROOT_W-2:0], 1'b1};
      end else begin
        sr_d[g]    = RemW'(cur);
        sroot_d[g] = {sroot_in[g][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // dividend with half the divisor added for rounding
  always_comb begin
    logic [NumW-1:0] num;
    for (int i = 0; i < 3; i++) begin
      num = {1'b0, sm_q[ROOT_W-1][i], {FRAC_W{1'b0}}}
          + NumW'(sroot_q[ROOT_W-1] >> 1);
      frem_d[i] = num[NumW-1 -: ROOT_W];
      flo_d[i]  = num[QUO_W-1:0];
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [RemW-1:0] dcur;
    dq_in[0]   = fq_q;
    drem_in[0] = frem_q;
    dlo_in[0]  = flo_q;
    dquo_in[0] = '0;
    for (int g = 1; g < QUO_W; g++) begin
      dq_in[g]   = dq_q[g-1];
      drem_in[g] = drem_q[g-1];
      dlo_in[g]  = dlo_q[g-1];
      dquo_in[g] = dquo_q[g-1];
    end
    for (int g = 0; g < QUO_W; g++) begin
      for (int i = 0; i < 3; i++) begin
        dcur = {drem_in[g][i], dlo_in[g][i][QUO_W-1]};
        dlo_d[g][i] = dlo_in[g][i] << 1;
        if (dcur >= {1'b0, dq_in[g]}) begin
          drem_d[g][i] = ROOT_W'(dcur - {1'b0, dq_in[g]});
          dquo_d[g][i] = {dquo_in[g][i][QUO_W-2:0], 1'b1};
        end else begin
          drem_d[g][i] = ROOT_W'(dcur);
          dquo_d[g][i] = {dquo_in[g][i][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  // clamp overshoot, zero vector stays zero, restore sign
  always_comb begin
    logic [COORD_W-1:0] um;
    for (int i = 0; i < 3; i++) begin
      if (dq_q[QUO_W-1] == '0) begin
        um = '0;
      end else if (dquo_q[QUO_W-1][i] > QUO_W'(UNIT_ONE)) begin
        um = COORD_W'(UNIT_ONE);
      end else begin
        um = COORD_W'(dquo_q[QUO_W-1][i]);
      end
      u_d[i] = band_q[Depth-2][SW+i] ? -um : um;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      mag2_q <= mag_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= mag_q[i] * mag_q[i];
        am_q[i] <= MAG_W'(mag2_q[i]);
      end
      s_q     <= SQ_W'(sq_q[0]) + SQ_W'(sq_q[1]) + SQ_W'(sq_q[2]);
      nx_q    <= nx_d;
      nm_q    <= nm_d;
      sx_q    <= sx_d;
      sr_q    <= sr_d;
      sroot_q <= sroot_d;
      sm_q    <= sm_d;
      fq_q    <= sroot_q[ROOT_W-1];
      frem_q  <= frem_d;
      flo_q   <= flo_d;
      dq_q    <= dq_in;
      drem_q  <= drem_d;
      dlo_q   <= dlo_d;
      dquo_q  <= dquo_d;
      u_q     <= u_d;
    end
  end

  assign valid_o = vld_q[Depth-1];
  assign u_o     = u_q;
  assign side_o  = band_q[Depth-1][SW-1:0];

endmodule

`default_nettype wire

>>> sv/lav_cross.sv
// two-stage cross product of signed 3-vectors: products, then differences
// depends on lav_pkg
`timescale 1ns / 1ps
`default_nettype none

module lav_cross #(
  parameter int unsigned AW = 16,
  parameter int unsigned BW = 16,
  parameter int unsigned RW = 31,
  parameter int unsigned SW = 96
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [2:0][AW-1:0] a_i,
  input  logic [2:0][BW-1:0] b_i,
  input  logic [SW-1:0]      side_i,
  output logic               valid_o,
  output logic [2:0][RW-1:0] r_o,
  output logic [SW-1:0]      side_o
);
  import lav_pkg::*;

  localparam int unsigned PW = AW + BW;

  logic [1:0]         vld_q;
  logic [SW-1:0]      side1_q, side2_q;
  logic [5:0][PW-1:0] p_q;
  logic [2:0][RW-1:0] r_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  // products, then differences
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0]  <= $signed(a_i[1]) * $signed(b_i[2]);
      p_q[1]  <= $signed(a_i[2]) * $signed(b_i[1]);
      p_q[2]  <= $signed(a_i[2]) * $signed(b_i[0]);
      p_q[3]  <= $signed(a_i[0]) * $signed(b_i[2]);
      p_q[4]  <= $signed(a_i[0]) * $signed(b_i[1]);
      p_q[5]  <= $signed(a_i[1]) * $signed(b_i[0]);
      r_q[0]  <= RW'($signed(p_q[0]) - $signed(p_q[1]));
      r_q[1]  <= RW'($signed(p_q[2]) - $signed(p_q[3]));
      r_q[2]  <= RW'($signed(p_q[4]) - $signed(p_q[5]));
      side1_q <= side_i;
      side2_q <= side1_q;
    end
  end

  assign valid_o = vld_q[1];
  assign r_o     = r_q;
  assign side_o  = side2_q;

endmodule

`default_nettype wire

>>> sv/lav_dot.sv
// translation column: negated row dot eye, rounded from Q1.14 x Q7.8 to Q15.8
// four stages; the last one is the output register of the block; depends on lav_pkg
`timescale 1ns / 1ps
`default_nettype none

module lav_dot #(
  parameter int unsigned SW = 144
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [2:0][2:0][lav_pkg::COORD_W-1:0] rows_i,
  input  lav_pkg::vec_t                        eye_i,
  input  logic [SW-1:0]                        side_i,
  output logic                                 valid_o,
  output logic [2:0][lav_pkg::SHIFT_W-1:0]     shift_o,
  output logic [SW-1:0]                        side_o
);
  import lav_pkg::*;

  localparam int unsigned PW   = 2 * COORD_W;
  localparam int unsigned DotW = PW + 3;
  localparam int unsigned RndW = DotW - FRAC_W;

  logic [3:0]                vld_q;
  logic [SW-1:0]             side_q [4];
  logic [2:0][2:0][PW-1:0]   prod_q;
  logic [2:0][DotW-1:0]      neg_d, neg_q;
  logic [2:0][RndW-1:0]      rnd_d, rnd_q;
  logic [2:0]                sgn_q;
  logic [2:0][SHIFT_W-1:0]   shift_d, shift_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // negated sum of products
  always_comb begin
    logic signed [DotW-1:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = DotW'($signed(prod_q[r][0])) + DotW'($signed(prod_q[r][1]))
          + DotW'($signed(prod_q[r][2]));
      neg_d[r] = -acc;
    end
  end

  // round half away from zero on the magnitude
  always_comb begin
    logic [DotW-1:0] mag;
    logic [DotW-1:0] rsum;
    for (int r = 0; r < 3; r++) begin
      mag      = neg_q[r][DotW-1] ? (~neg_q[r] + DotW'(1)) : neg_q[r];
      rsum     = mag + DotW'(1 << (FRAC_W - 1));
      rnd_d[r] = rsum[DotW-1:FRAC_W];
    end
  end

  // restore sign; the magnitude stays below 2^21, so the 24-bit field never saturates
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shift_d[r] = sgn_q[r] ? -SHIFT_W'(rnd_q[r]) : SHIFT_W'(rnd_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(rows_i[r][c]) * $signed(eye_i[c]);
        end
        sgn_q[r] <= neg_q[r][DotW-1];
      end
      neg_q     <= neg_d;
      rnd_q     <= rnd_d;
      shift_q   <= shift_d;
      side_q[0] <= side_i;
      for (int k = 1; k < 4; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[3];
  assign shift_o = shift_q;
  assign side_o  = side_q[3];

endmodule

`default_nettype wire

>>> sv/look_at_view_matrix_top.sv
// top level of the look-at view matrix unit: stream ports and stage chaining
// depends on lav_pkg, lav_unit, lav_cross, lav_dot
`timescale 1ns / 1ps
`default_nettype none

// Builds a look-at view matrix from one camera setup per request: eye, target and
// up hint in Q7.8 in, rotation rows side, true up and back in Q1.14 and the
// translation column in Q15.8 out. The pipeline takes a new request every cycle while
// the output is not stalled; most of its stages lie in the two unit-length
// scalers, each a 31-stage square root followed by 15-stage dividers.
// The whole pipeline holds while a finished result waits on the output with tready
// low. A zero forward vector (target equal to eye) yields an all-zero result; a zero
// side vector (up hint parallel to forward, or zero) zeroes side, true up and the
// first two translations.
module look_at_view_matrix_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_hint_x, up_hint_y, up_hint_z
  input  logic [lav_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // side_x/y/z, true_up_x/y/z, back_x/y/z, shift_x, shift_y, shift_z
  output logic [lav_pkg::OUT_W-1:0] m_axis_tdata
);
  import lav_pkg::*;

  localparam coord_t UnitPos = COORD_W'(UNIT_ONE);
  localparam coord_t UnitNeg = -COORD_W'(UNIT_ONE);

  logic en;

  vec_t [2:0]              in_vec;
  logic [2:0][DIFF_W-1:0]  diff_d, diff_q;
  vec_t                    eye0_q, up0_q;
  logic                    v0_q;

  logic                    vf;
  vec_t                    fwd_u, eye_f, up_f;

  logic                    vc1;
  logic [2:0][RAW_W-1:0]   raw1;
  vec_t                    fwd_c, eye_c;

  logic                    vs;
  vec_t                    side_u, fwd_s, eye_s;

  logic                    vc2;
  logic [2:0][RAW_W-1:0]   raw2;
  vec_t                    side_c, fwd_c2, eye_c2;

  vec_t                    tup_d, back_d;
  vec_t [2:0]              rows_q;
  vec_t                    eye_t_q;
  logic                    vt_q;

  vec_t [2:0]              rows_o;
  logic [2:0][SHIFT_W-1:0] shift_o;

  // one stall for the whole pipeline, released when the output is free
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // forward difference
  assign in_vec = s_axis_tdata;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_d[i] = DIFF_W'($signed(in_vec[1][i])) - DIFF_W'($signed(in_vec[0][i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vt_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
      vt_q <= vc2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_q  <= diff_d;
      eye0_q  <= in_vec[0];
      up0_q   <= in_vec[2];
      rows_q  <= {back_d, tup_d, side_c};
      eye_t_q <= eye_c2;
    end
  end

  // forward = unit(target - eye)
  lav_unit #(
    .CW (DIFF_W),
    .SW (6 * COORD_W)
  ) u_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .c_i     (diff_q),
    .side_i  ({up0_q, eye0_q}),
    .valid_o (vf),
    .u_o     (fwd_u),
    .side_o  ({up_f, eye_f})
  );

  // forward x up hint
  lav_cross #(
    .AW (COORD_W),
    .BW (COORD_W),
    .RW (RAW_W),
    .SW (6 * COORD_W)
  ) u_cross_fu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vf),
    .a_i     (fwd_u),
    .b_i     (up_f),
    .side_i  ({fwd_u, eye_f}),
    .valid_o (vc1),
    .r_o     (raw1),
    .side_o  ({fwd_c, eye_c})
  );

  // side = unit(forward x up hint)
  lav_unit #(
    .CW (RAW_W),
    .SW (6 * COORD_W)
  ) u_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vc1),
    .c_i     (raw1),
    .side_i  ({fwd_c, eye_c}),
    .valid_o (vs),
    .u_o     (side_u),
    .side_o  ({fwd_s, eye_s})
  );

  // side x forward
  lav_cross #(
    .AW (COORD_W),
    .BW (COORD_W),
    .RW (RAW_W),
    .SW (9 * COORD_W)
  ) u_cross_sf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vs),
    .a_i     (side_u),
    .b_i     (fwd_s),
    .side_i  ({side_u, fwd_s, eye_s}),
    .valid_o (vc2),
    .r_o     (raw2),
    .side_o  ({side_c, fwd_c2, eye_c2})
  );

  // true up back to Q1.14, back = -forward
  always_comb begin
    logic [RAW_W-1:0]   rmag;
    logic [RAW_W-1:0]   rsum;
    logic [COORD_W:0]   rq;
    logic [COORD_W-1:0] rc;
    for (int i = 0; i < 3; i++) begin
      rmag = raw2[i][RAW_W-1] ? (~raw2[i] + RAW_W'(1)) : raw2[i];
      rsum = rmag + RAW_W'(1 << (FRAC_W - 1));
      rq   = rsum[RAW_W-1:FRAC_W];
      rc   = (rq > (COORD_W + 1)'(UNIT_ONE)) ? COORD_W'(UNIT_ONE) : COORD_W'(rq);
      tup_d[i]  = raw2[i][RAW_W-1] ? -rc : rc;
      back_d[i] = -fwd_c2[i];
    end
  end

  // translation column and output register
  lav_dot #(
    .SW (9 * COORD_W)
  ) u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vt_q),
    .rows_i  (rows_q),
    .eye_i   (eye_t_q),
    .side_i  (rows_q),
    .valid_o (m_axis_tvalid),
    .shift_o (shift_o),
    .side_o  (rows_o)
  );

  assign m_axis_tdata = {shift_o, rows_o};

  // rotation range check
  logic rot_in_range;
  always_comb begin
    rot_in_range = 1'b1;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ($signed(rows_o[r][c]) > UnitPos || $signed(rows_o[r][c]) < UnitNeg) begin
          rot_in_range = 1'b0;
        end
      end
    end
  end

  // every rotation entry stays within one unit
  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> rot_in_range)
    else $error("rotation entry out of unit range");

  // zero forward collapses the whole result to zero
  a_zero_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && rows_o[2] == '0) |->
      (rows_o[0] == '0 && rows_o[1] == '0 && shift_o == '0))
    else $error("zero forward with nonzero result");

  // zero side leaves no true up and no first two translations
  a_zero_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && rows_o[0] == '0) |->
      (rows_o[1] == '0 && shift_o[0] == '0 && shift_o[1] == '0))
    else $error("zero side with nonzero true up or translation");

endmodule

`default_nettype wire

>>> tb/look_at_view_matrix_top_tb.sv
// testbench of the look-at view matrix unit: directed and random camera setups
// depends on lav_pkg and look_at_view_matrix_top; predicts each matrix bit for bit
`timescale 1ns / 1ps

module look_at_view_matrix_top_tb;
  import lav_pkg::*;

  localparam int unsigned LATENCY   = 122;
  localparam int unsigned N_RANDOM  = 1900;
  localparam longint      CYCLE_MAX = 400000;

  typedef struct packed {
    logic signed [23:0] shift_z, shift_y, shift_x;
    logic signed [15:0] back_z, back_y, back_x;
    logic signed [15:0] up_z, up_y, up_x;
    logic signed [15:0] side_z, side_y, side_x;
  } matrix_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  matrix_t     matrix_q[$];
  int unsigned n_errors = 0;
  longint      cycle_cnt = 0;

  look_at_view_matrix_top u_top (.*);

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint rnd_shift(longint v, int sh);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // scale to unit length in Q1.14, zero stays zero
  function automatic void to_unit(input longint c[3], output longint u[3]);
    logic [63:0] s, x, res, bit_v, q, num, r;
    int k;
    s = 0;
    k = 0;
    for (int i = 0; i < 3; i++) s += (c[i] < 0 ? -c[i] : c[i]) ** 2;
    if (s == 0) begin
      u = '{0, 0, 0};
      return;
    end
    while (k < 60 && s < (64'd1 << (60 - k))) k += 2;
    x = s << k;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    q = res;
    for (int i = 0; i < 3; i++) begin
      num = 64'(c[i] < 0 ? -c[i] : c[i]) << (14 + k / 2);
      r = (num + q / 2) / q;
      if (r > UNIT_ONE) r = UNIT_ONE;
      u[i] = c[i] < 0 ? -longint'(r) : longint'(r);
    end
  endfunction

  function automatic void cross_prod(input longint a[3], input longint b[3],
                                     output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint neg_eye_dot(longint row[3], longint eye[3]);
    longint d;
    d = row[0] * eye[0] + row[1] * eye[1] + row[2] * eye[2];
    return clampv(rnd_shift(-d, 14), -8388608, 8388607);
  endfunction

  function automatic matrix_t view_matrix(logic [IN_W-1:0] req);
    longint eye[3], dif[3], up[3], fwd[3], raw[3], side[3], tup[3], back[3];
    matrix_t m;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(req[16*i +: 16]));
      dif[i] = longint'($signed(req[16*(3+i) +: 16])) - eye[i];
      up[i]  = longint'($signed(req[16*(6+i) +: 16]));
    end
    to_unit(dif, fwd);
    cross_prod(fwd, up, raw);
    to_unit(raw, side);
    cross_prod(side, fwd, raw);
    for (int i = 0; i < 3; i++) begin
      tup[i] = clampv(rnd_shift(raw[i], 14), -16384, 16384);
      back[i] = -fwd[i];
    end
    m.side_x = 16'(side[0]); m.side_y = 16'(side[1]); m.side_z = 16'(side[2]);
    m.up_x = 16'(tup[0]); m.up_y = 16'(tup[1]); m.up_z = 16'(tup[2]);
    m.back_x = 16'(back[0]); m.back_y = 16'(back[1]); m.back_z = 16'(back[2]);
    m.shift_x = 24'(neg_eye_dot(side, eye));
    m.shift_y = 24'(neg_eye_dot(tup, eye));
    m.shift_z = 24'(neg_eye_dot(back, eye));
    return m;
  endfunction

  // send one request after a random gap
  task automatic send_setup(logic [IN_W-1:0] req);
    int gap;
    gap = $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    matrix_q.push_back(view_matrix(req));
  endtask

  function automatic logic [IN_W-1:0] pack_setup(logic [15:0] e[3], logic [15:0] t[3],
                                                 logic [15:0] u[3]);
    return {u[2], u[1], u[0], t[2], t[1], t[0], e[2], e[1], e[0]};
  endfunction

  // extremes, zero forward, parallel and zero up hint
  task automatic test_directed();
    send_setup('0);
    send_setup({IN_W{1'b1}});
    send_setup(pack_setup('{16'h8000, 16'h8000, 16'h8000}, '{16'h7fff, 16'h7fff, 16'h7fff},
                          '{16'h0000, 16'h0100, 16'h0000}));
    send_setup(pack_setup('{16'h7fff, 16'h7fff, 16'h7fff}, '{16'h8000, 16'h8000, 16'h8000},
                          '{16'h7fff, 16'h8000, 16'h7fff}));
    send_setup(pack_setup('{16'h0100, 16'h0200, 16'h0300}, '{16'h0100, 16'h0200, 16'h0300},
                          '{16'h0000, 16'h0100, 16'h0000}));
    send_setup(pack_setup('{16'h0000, 16'h0000, 16'h0000}, '{16'h0000, 16'h0000, 16'h0100},
                          '{16'h0000, 16'h0000, 16'h0300}));
    send_setup(pack_setup('{16'h1000, 16'h0000, 16'h0000}, '{16'h0000, 16'h0000, 16'hf000},
                          '{16'h0000, 16'h0000, 16'h0000}));
    send_setup(pack_setup('{16'h8000, 16'h7fff, 16'h8000}, '{16'h7fff, 16'h8000, 16'h7fff},
                          '{16'h8000, 16'h8000, 16'h8000}));
    send_setup(pack_setup('{16'h7fff, 16'h8000, 16'h0000}, '{16'h8000, 16'h7fff, 16'h0001},
                          '{16'h0001, 16'h0000, 16'h0000}));
    send_setup(pack_setup('{16'h0000, 16'h0000, 16'h0000}, '{16'h0001, 16'h0001, 16'h0001},
                          '{16'hffff, 16'h0001, 16'h0000}));
  endtask

  // random setups, some with small vectors or a degenerate case
  task automatic test_random();
    logic [IN_W-1:0] req;
    for (int n = 0; n < N_RANDOM; n++) begin
      for (int i = 0; i < 9; i++) req[16*i +: 16] = 16'($urandom);
      case ($urandom_range(0, 7))
        0: req[48 +: 48] = req[0 +: 48];
        1: req[96 +: 48] = '0;
        2: for (int i = 0; i < 9; i++) req[16*i +: 16] = 16'($signed($urandom_range(0, 8)) - 4);
        3: for (int i = 0; i < 3; i++)
             req[16*(6+i) +: 16] = req[16*(3+i) +: 16] - req[16*i +: 16];
        default: ;
      endcase
      send_setup(req);
    end
  endtask

  // result checker with random output stalls
  initial begin
    matrix_t got, exp_m;
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 18);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = matrix_t'(m_axis_tdata);
      if (matrix_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        n_errors++;
      end else begin
        exp_m = matrix_q.pop_front();
        if (got.side_x !== exp_m.side_x)
          begin $error("side_x exp %0d got %0d", exp_m.side_x, got.side_x); n_errors++; end
        if (got.side_y !== exp_m.side_y)
          begin $error("side_y exp %0d got %0d", exp_m.side_y, got.side_y); n_errors++; end
        if (got.side_z !== exp_m.side_z)
          begin $error("side_z exp %0d got %0d", exp_m.side_z, got.side_z); n_errors++; end
        if (got.up_x !== exp_m.up_x)
          begin $error("true_up_x exp %0d got %0d", exp_m.up_x, got.up_x); n_errors++; end
        if (got.up_y !== exp_m.up_y)
          begin $error("true_up_y exp %0d got %0d", exp_m.up_y, got.up_y); n_errors++; end
        if (got.up_z !== exp_m.up_z)
          begin $error("true_up_z exp %0d got %0d", exp_m.up_z, got.up_z); n_errors++; end
        if (got.back_x !== exp_m.back_x)
          begin $error("back_x exp %0d got %0d", exp_m.back_x, got.back_x); n_errors++; end
        if (got.back_y !== exp_m.back_y)
          begin $error("back_y exp %0d got %0d", exp_m.back_y, got.back_y); n_errors++; end
        if (got.back_z !== exp_m.back_z)
          begin $error("back_z exp %0d got %0d", exp_m.back_z, got.back_z); n_errors++; end
        if (got.shift_x !== exp_m.shift_x)
          begin $error("shift_x exp %0d got %0d", exp_m.shift_x, got.shift_x); n_errors++; end
        if (got.shift_y !== exp_m.shift_y)
          begin $error("shift_y exp %0d got %0d", exp_m.shift_y, got.shift_y); n_errors++; end
        if (got.shift_z !== exp_m.shift_z)
          begin $error("shift_z exp %0d got %0d", exp_m.shift_z, got.shift_z); n_errors++; end
      end
    end
  end

  // test sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (n_errors == 0 && matrix_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
